// ===== hdl/grt_pkg.sv =====
package grt_pkg;

    // Default build-time sizes
    localparam int MAX_GLYPHS_DEF      = 256;
    localparam int MAX_GLYPH_ROWS_DEF  = 32;
    localparam int MAX_GLYPH_WIDTH_DEF = 16;
    localparam int MARGIN_PIXELS_DEF   = 20;

    // 32-bit framebuffer pixels
    localparam int PIXEL_BYTES = 4;

    // Register field widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SCREEN_W    = 13;
    localparam int GWIDTH_W    = 5;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_PITCH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_HEIGHT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_WIDTH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_COUNT  = 3'd4;

    // Register reset values
    localparam int RST_LINE_PITCH   = 4096;
    localparam int RST_SCREEN_WIDTH = 1024;
    localparam int RST_GLYPH_HEIGHT = 16;
    localparam int RST_GLYPH_WIDTH  = 8;
    localparam int RST_GLYPH_COUNT  = 256;

    // Item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  char_code;
        logic [4:0]  font_row;
        logic [15:0] row_pattern;
        logic        string_start;
    } item_t;

    typedef struct packed {
        logic [31:0] pixel_address;
        logic [15:0] pixel_bits;
        logic        last_row;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_ROWS
    } grt_state_t;

    // Divider request and status
    typedef struct packed {
        logic                start;
        logic [SCREEN_W-1:0] dividend;
        logic [GWIDTH_W-1:0] divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [SCREEN_W-1:0] quotient;
    } div_status_t;

endpackage

// ===== hdl/grt_divider.sv =====
module grt_divider (
    input  logic                 clk,
    input  logic                 rst_n,
    input  grt_pkg::div_ctrl_t   ctrl,
    output grt_pkg::div_status_t status
);
    import grt_pkg::*;

    localparam int CNT_W = $clog2(SCREEN_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [GWIDTH_W-1:0] rem_reg, rem_next;
    logic [SCREEN_W-1:0] quo_reg, quo_next;
    logic [GWIDTH_W-1:0] divisor_reg, divisor_next;
    logic [GWIDTH_W:0]   trial;
    logic [GWIDTH_W:0]   diff;
    logic                fits;

    // One quotient bit per cycle, restoring
    always_comb
    begin
        trial = {rem_reg, quo_reg[SCREEN_W-1]};
        diff  = trial - {1'b0, divisor_reg};
        fits  = trial >= {1'b0, divisor_reg};
    end

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (ctrl.start)
        begin
            // restart with fresh operands
            busy_next    = 1'b1;
            count_next   = '0;
            rem_next     = '0;
            quo_next     = ctrl.dividend;
            divisor_next = ctrl.divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[GWIDTH_W-1:0] : trial[GWIDTH_W-1:0];
            quo_next   = {quo_reg[SCREEN_W-2:0], fits};
            count_next = count_reg + CNT_W'(1);
            if (count_reg == CNT_W'(SCREEN_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign status.busy     = busy_reg;
    assign status.done     = done_reg;
    assign status.quotient = quo_reg;

endmodule

// ===== hdl/glyph_text_renderer_core.sv =====
// Bitmap text renderer. Load items write one 16-bit font row into the glyph
// store. A draw item is accepted, forms the row address in ST_ADDR, then
// does one glyph store read per glyph row in ST_ROWS, which sets the pace;
// results leave at one per cycle while the result side does not stall, and
// a new item is accepted while the last rows still drain. Each write to a
// known register (index 0 to 4) holds off items while the glyphs-per-line
// figure is divided out, one quotient bit per cycle. The glyph store has no
// reset; drawing a row that was never loaded gives undefined pixel bits.
module glyph_text_renderer_core #(
    parameter int MAX_GLYPHS      = grt_pkg::MAX_GLYPHS_DEF,
    parameter int MAX_GLYPH_ROWS  = grt_pkg::MAX_GLYPH_ROWS_DEF,
    parameter int MAX_GLYPH_WIDTH = grt_pkg::MAX_GLYPH_WIDTH_DEF,
    parameter int MARGIN_PIXELS   = grt_pkg::MARGIN_PIXELS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  grt_pkg::item_t                   item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output grt_pkg::result_t                 result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [grt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [grt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import grt_pkg::*;

    localparam int STORE_DEPTH = MAX_GLYPHS * MAX_GLYPH_ROWS;
    localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int GLYPH_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int ROW_W   = (MAX_GLYPH_ROWS > 1) ? $clog2(MAX_GLYPH_ROWS) : 1;
    localparam int HGT_W   = $clog2(MAX_GLYPH_ROWS + 1);
    localparam int WID_W   = $clog2(MAX_GLYPH_WIDTH + 1);

    localparam logic [SCREEN_W-1:0] MARGINS = SCREEN_W'(2 * MARGIN_PIXELS);

    // Derived values after reset
    localparam int RST_H    = (RST_GLYPH_HEIGHT > MAX_GLYPH_ROWS) ? MAX_GLYPH_ROWS
                                                                  : RST_GLYPH_HEIGHT;
    localparam int RST_W    = (RST_GLYPH_WIDTH > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH
                                                                  : RST_GLYPH_WIDTH;
    localparam int RST_SPAN = (RST_SCREEN_WIDTH > 2 * MARGIN_PIXELS)
                              ? RST_SCREEN_WIDTH - 2 * MARGIN_PIXELS : 0;
    localparam int RST_Q    = RST_SPAN / RST_W;
    localparam int RST_GPL  = (RST_Q == 0) ? 1 : RST_Q;
    localparam logic [31:0] RST_LINE_STEP  = 32'(RST_LINE_PITCH * RST_H);
    localparam logic [31:0] RST_MARGIN_OFF = 32'(MARGIN_PIXELS * RST_LINE_PITCH
                                                 + MARGIN_PIXELS * PIXEL_BYTES);

    // Configuration registers
    logic [15:0]         pitch_reg;
    logic [SCREEN_W-1:0] screen_reg;
    logic [5:0]          gheight_reg;
    logic [GWIDTH_W-1:0] gwidth_reg;
    logic [8:0]          gcount_reg;
    logic [SCREEN_W-1:0] gpl_reg;
    logic [31:0]         line_step_reg, line_step_next;
    logic [31:0]         margin_off_reg, margin_off_next;
    logic                div_pending_reg, div_pending_next;

    // Sequencer state
    grt_state_t          state_reg, state_next;
    logic [SCREEN_W-1:0] col_reg;
    logic [31:0]         lbase_reg;
    logic [GLYPH_W-1:0]  glyph_reg;
    logic [ADDR_W-1:0]   gbase_reg;
    logic [ROW_W-1:0]    y_reg;
    logic [31:0]         rowaddr_reg;

    // Read pipeline and result register
    logic [15:0]         glyph_store [STORE_DEPTH];
    logic [15:0]         rd_data_reg;
    logic [31:0]         rd_pixaddr_reg;
    logic                rd_last_reg;
    logic                rd_valid_reg, rd_valid_next;
    result_t             result_reg;
    logic                result_valid_reg;

    logic                cfg_we, cfg_known;
    logic [HGT_W-1:0]    h_eff;
    logic [WID_W-1:0]    w_eff;
    logic [15:0]         mask;
    logic                item_accept, draw_accept, store_we;
    logic [ADDR_W-1:0]   wr_addr, rd_addr;
    logic                rd_en, move, row_last;
    logic [SCREEN_W-1:0] col_start, col_pre, col_inc;
    logic [31:0]         lb_start, lb_pre;
    logic [GLYPH_W-1:0]  glyph_sel;
    logic [17:0]         col_x;
    div_ctrl_t           div_ctrl;
    div_status_t         div_status;

    // Clamp glyph size
    always_comb
    begin
        if (gheight_reg == '0)
            h_eff = HGT_W'(1);
        else if (int'(gheight_reg) > MAX_GLYPH_ROWS)
            h_eff = HGT_W'(MAX_GLYPH_ROWS);
        else
            h_eff = HGT_W'(gheight_reg);
        if (gwidth_reg == '0)
            w_eff = WID_W'(1);
        else if (int'(gwidth_reg) > MAX_GLYPH_WIDTH)
            w_eff = WID_W'(MAX_GLYPH_WIDTH);
        else
            w_eff = WID_W'(gwidth_reg);
        mask = 16'((17'd1 << w_eff) - 17'd1);
    end

    // Per-configuration products, settled well before the next item
    always_comb
    begin
        line_step_next  = 32'(pitch_reg) * 32'(h_eff);
        margin_off_next = 32'(pitch_reg) * 32'(MARGIN_PIXELS)
                        + 32'(MARGIN_PIXELS * PIXEL_BYTES);
    end

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_known        = cfg_index inside {[REG_LINE_PITCH:REG_GLYPH_COUNT]};
        div_pending_next = cfg_we && cfg_known;
    end

    // Glyphs per line divider
    always_comb
    begin
        div_ctrl.start    = div_pending_reg;
        div_ctrl.dividend = (screen_reg > MARGINS) ? screen_reg - MARGINS : '0;
        div_ctrl.divisor  = GWIDTH_W'(w_eff);
    end

    grt_divider u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (div_ctrl),
        .status (div_status)
    );

    // Write configuration and pick up the quotient
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg       <= 16'(RST_LINE_PITCH);
            screen_reg      <= SCREEN_W'(RST_SCREEN_WIDTH);
            gheight_reg     <= 6'(RST_GLYPH_HEIGHT);
            gwidth_reg      <= GWIDTH_W'(RST_GLYPH_WIDTH);
            gcount_reg      <= 9'(RST_GLYPH_COUNT);
            gpl_reg         <= SCREEN_W'(RST_GPL);
            line_step_reg   <= RST_LINE_STEP;
            margin_off_reg  <= RST_MARGIN_OFF;
            div_pending_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LINE_PITCH:   pitch_reg   <= cfg_data;
                    REG_SCREEN_WIDTH: screen_reg  <= cfg_data[SCREEN_W-1:0];
                    REG_GLYPH_HEIGHT: gheight_reg <= cfg_data[5:0];
                    REG_GLYPH_WIDTH:  gwidth_reg  <= cfg_data[GWIDTH_W-1:0];
                    REG_GLYPH_COUNT:  gcount_reg  <= cfg_data[8:0];
                    default:          ;
                endcase
            end
            if (div_status.done)
                gpl_reg <= (div_status.quotient == '0) ? SCREEN_W'(1)
                                                       : div_status.quotient;
            line_step_reg   <= line_step_next;
            margin_off_reg  <= margin_off_next;
            div_pending_reg <= div_pending_next;
        end
    end

    // Drain one read into the result register
    assign move     = rd_valid_reg && (!result_valid_reg || !result_stall);
    assign row_last = (HGT_W'(y_reg) + HGT_W'(1)) == h_eff;

    // Sequencer outputs; hold items until the new quotient is in place
    always_comb
    begin
        item_stall = (state_reg != ST_IDLE) || div_pending_reg || div_status.busy
                   || div_status.done || cfg_valid;
        rd_en      = (state_reg == ST_ROWS) && (!rd_valid_reg || move);
    end

    assign item_accept = item_valid && !item_stall;
    assign draw_accept = item_accept && (item.command == CMD_DRAW);
    assign store_we    = item_accept && (item.command == CMD_LOAD)
                       && (int'(item.char_code) < MAX_GLYPHS)
                       && (int'(item.font_row) < MAX_GLYPH_ROWS);

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (draw_accept)
                    state_next = ST_ADDR;
            end
            ST_ADDR:
                state_next = ST_ROWS;
            ST_ROWS:
            begin
                if (rd_en && row_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Text position before drawing: string start, then wrap if past the line
    always_comb
    begin
        col_start = item.string_start ? '0 : col_reg;
        lb_start  = item.string_start ? '0 : lbase_reg;
        if (col_start >= gpl_reg)
        begin
            col_pre = '0;
            lb_pre  = lb_start + line_step_reg;
        end
        else
        begin
            col_pre = col_start;
            lb_pre  = lb_start;
        end
        if ((item.char_code != '0) && ({1'b0, item.char_code} < gcount_reg)
            && (int'(item.char_code) < MAX_GLYPHS))
            glyph_sel = GLYPH_W'(item.char_code);
        else
            glyph_sel = '0;
        col_inc = col_reg + SCREEN_W'(1);
        col_x   = {5'd0, col_reg} * {13'd0, GWIDTH_W'(w_eff)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            lbase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (draw_accept)
            begin
                col_reg   <= col_pre;
                lbase_reg <= lb_pre;
            end
            else if (state_reg == ST_ADDR)
            begin
                // advance one slot, wrap after the last one on the line
                if (col_inc >= gpl_reg)
                begin
                    col_reg   <= '0;
                    lbase_reg <= lbase_reg + line_step_reg;
                end
                else
                    col_reg <= col_inc;
            end
        end
    end

    // Glyph and row address datapath
    always_ff @(posedge clk)
    begin
        if (draw_accept)
            glyph_reg <= glyph_sel;
        if (state_reg == ST_ADDR)
        begin
            gbase_reg   <= ADDR_W'(int'(glyph_reg) * MAX_GLYPH_ROWS);
            rowaddr_reg <= margin_off_reg + lbase_reg
                         + 32'(col_x) * 32'(PIXEL_BYTES);
            y_reg       <= '0;
        end
        else if (rd_en)
        begin
            y_reg       <= y_reg + ROW_W'(1);
            rowaddr_reg <= rowaddr_reg + 32'(pitch_reg);
        end
    end

    assign wr_addr = ADDR_W'(int'(item.char_code) * MAX_GLYPH_ROWS + int'(item.font_row));
    assign rd_addr = gbase_reg + ADDR_W'(y_reg);

    // Glyph store; loads and draw reads never share a cycle
    always_ff @(posedge clk)
    begin
        if (store_we)
            glyph_store[wr_addr] <= item.row_pattern;
        if (rd_en)
        begin
            rd_data_reg    <= glyph_store[rd_addr];
            rd_pixaddr_reg <= rowaddr_reg;
            rd_last_reg    <= row_last;
        end
    end

    always_comb
    begin
        rd_valid_next = rd_valid_reg;
        if (rd_en)
            rd_valid_next = 1'b1;
        else if (move)
            rd_valid_next = 1'b0;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_valid_next;
            if (move)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            result_reg.pixel_address <= rd_pixaddr_reg;
            result_reg.pixel_bits    <= rd_data_reg & mask;
            result_reg.last_row      <= rd_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hdl/grt_checker.sv =====
module grt_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             item_valid,
    input logic                             item_stall,
    input grt_pkg::item_t                   item,
    input logic                             result_valid,
    input logic                             result_stall,
    input grt_pkg::result_t                 result,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [grt_pkg::CFG_INDEX_W-1:0]  cfg_index
);
    import grt_pkg::*;

    // Stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // A draw keeps the item side closed while its rows are issued
    a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.command == CMD_DRAW) |=> item_stall)
        else $error("item accepted straight after a draw");

    // A write to a known register closes the item side for the division
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index <= REG_GLYPH_COUNT) |=> item_stall)
        else $error("item side open straight after a register write");

    // Never take an item in the same cycle as a register write
    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> item_stall)
        else $error("item side open during a register write");

endmodule

bind glyph_text_renderer_core grt_checker u_grt_checker (.*);
